/* rtl/core/bcm_pkg.sv */
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types, constants and register codes of the bright channel max filter.
// ----------------------------------------------------------------------------
package bcm_pkg;

   // default sizes of the line store, and the image height limit
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_WINDOW_DEF = 32;
   localparam int MAX_HEIGHT     = 2048;

   // field and counter widths
   localparam int PIX_W   = 8;
   localparam int DIM_W   = 12;
   localparam int WIN_W   = 6;
   localparam int POS_W   = 23;
   localparam int IDX_W   = 14;
   localparam int PROD_W  = 24;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // register reset values
   localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;
   localparam logic [WIN_W-1:0] WINDOW_RST = 6'd9;

   // register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WINDOW = 2'd2;

   // request opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic             opcode;
      logic [PIX_W-1:0] chan_first;
      logic [PIX_W-1:0] chan_second;
      logic [PIX_W-1:0] chan_third;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] bright_value;
      logic             row_end;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [WIN_W-1:0] window_size;
      logic             restart;
   } cfg_type;

endpackage

/* rtl/core/bcm_line_store.sv */
// ----------------------------------------------------------------------------
// bcm_line_store
// Single-port-write, single-port-read line memory with registered read data.
// ----------------------------------------------------------------------------
module bcm_line_store
   import bcm_pkg::*;
#(
   parameter int AddrW = 16
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [PIX_W-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [PIX_W-1:0] rd_data
);

   logic [PIX_W-1:0] mem [2**AddrW];
   logic [PIX_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/bcm_csr.sv */
// ----------------------------------------------------------------------------
// bcm_csr
// Configuration registers behind an APB-style port, saturated on write.
// ----------------------------------------------------------------------------
module bcm_csr
   import bcm_pkg::*;
#(
   parameter int MaxWidth  = MAX_WIDTH_DEF,
   parameter int MaxWindow = MAX_WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [WIN_W-1:0] window_ff, window_in;
   logic             wr_stb;
   logic [1:0]       reg_idx;
   int               wv, hv, kv;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // saturate written values
   always_comb begin
      wv = int'(csr_pwdata[DIM_W-1:0]);
      kv = int'(csr_pwdata[WIN_W-1:0]);
      hv = wv;
      if (wv < 1) wv = 1;
      if (wv > MaxWidth) wv = MaxWidth;
      if (hv < 1) hv = 1;
      if (hv > MAX_HEIGHT) hv = MAX_HEIGHT;
      if (kv < 1) kv = 1;
      if (kv > MaxWindow) kv = MaxWindow;
   end

   // register update
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      window_in = window_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_WIDTH:  width_in  = DIM_W'(wv);
            REG_HEIGHT: height_in = DIM_W'(hv);
            REG_WINDOW: window_in = WIN_W'(kv);
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         window_ff <= WINDOW_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         window_ff <= window_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         REG_WINDOW: csr_prdata = CSR_DW'(window_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // any write to a known register restarts the frame
   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.window_size  = window_ff;
   assign cfg.restart      = wr_stb && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT
                                        || reg_idx == REG_WINDOW);

endmodule

/* rtl/core/bright_channel_max_filter.sv */
// ----------------------------------------------------------------------------
// bright_channel_max_filter
// Flow: one request at a time; req_stall is high outside the idle state. A request
// that yields a result starts a scan of the k*k window entries, k the window side;
// each in-image entry is read from the line store through S_MUL, S_RD and S_CMP, and
// S_OUT loads the result. Requests without a result do not leave the idle state.
// Reset: synchronous; registers to 640x480, window 9, frame counters to zero.
// ----------------------------------------------------------------------------
module bright_channel_max_filter
   import bcm_pkg::*;
#(
   parameter int MaxWidth  = MAX_WIDTH_DEF,
   parameter int MaxWindow = MAX_WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // depth is a power of two, so position modulo depth is a bit slice
   localparam int AddrW = $clog2(MaxWidth * MaxWindow);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_RD   = 5'b00100,
      S_CMP  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   cfg_type          cfg;
   state_type        state_ff, state_in;
   logic [DIM_W-1:0] in_col_ff, in_col_in, in_row_ff, in_row_in;
   logic [POS_W-1:0] in_pos_ff, in_pos_in, lag;
   logic [DIM_W-1:0] out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic [IDX_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [IDX_W-1:0] col_last_ff, col_last_in, row_first_ff, row_first_in;
   logic [IDX_W-1:0] row_last_ff, row_last_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PIX_W-1:0] best_ff, best_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             req_acc, in_done, elem_ok, elem_last, out_free;
   logic             last_col, last_row;
   logic [WIN_W-1:0] a_w, b_w;
   logic [PIX_W-1:0] pix_max, rd_data;
   logic             wr_en, rd_en;
   logic [AddrW-1:0] rd_addr;

   bcm_csr #(
      .MaxWidth  (MaxWidth),
      .MaxWindow (MaxWindow)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bcm_line_store #(
      .AddrW (AddrW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AddrW'(in_pos_ff)),
      .wr_data (pix_max),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window anchor split
   assign a_w = {1'b0, cfg.window_size[WIN_W-1:1]};
   assign b_w = cfg.window_size - 6'd1 - a_w;

   // output lag in pixels, from the current registers
   assign lag = POS_W'(POS_W'(b_w) * POS_W'(cfg.image_width) + POS_W'(b_w));

   // per-pixel channel maximum
   always_comb begin
      pix_max = req_data.chan_first;
      if (req_data.chan_second > pix_max) pix_max = req_data.chan_second;
      if (req_data.chan_third > pix_max) pix_max = req_data.chan_third;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign in_done   = (in_row_ff >= cfg.image_height);
   assign wr_en     = req_acc && req_data.opcode == OP_PIXEL && !in_done;
   assign rd_en     = (state_ff == S_RD);
   assign rd_addr   = AddrW'(prod_ff + PROD_W'(col_ff[DIM_W-1:0]));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // current window entry inside the image, and end of the scan
   assign elem_ok = !col_ff[IDX_W-1] && col_ff < IDX_W'(cfg.image_width)
                    && !row_ff[IDX_W-1] && row_ff < IDX_W'(cfg.image_height);
   assign elem_last = (row_ff == row_last_ff) && (col_ff == col_last_ff);

   assign last_col = (13'(out_col_ff) + 13'd1) == 13'(cfg.image_width);
   assign last_row = (13'(out_row_ff) + 13'd1) == 13'(cfg.image_height);

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_pos_in    = in_pos_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      col_last_in  = col_last_ff;
      row_first_in = row_first_ff;
      row_last_in  = row_last_ff;
      prod_in      = prod_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      // scan setup, used when a request produces a result
      if (state_ff == S_IDLE) begin
         col_in       = IDX_W'(out_col_ff) - IDX_W'(a_w);
         row_in       = IDX_W'(out_row_ff) - IDX_W'(a_w);
         row_first_in = IDX_W'(out_row_ff) - IDX_W'(a_w);
         col_last_in  = IDX_W'(out_col_ff) + IDX_W'(b_w);
         row_last_in  = IDX_W'(out_row_ff) + IDX_W'(b_w);
         best_in      = '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_data.opcode == OP_PIXEL && !in_done) begin
                  in_pos_in = in_pos_ff + 23'd1;
                  if (13'(in_col_ff) + 13'd1 >= 13'(cfg.image_width)) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + 12'd1;
                  end else begin
                     in_col_in = in_col_ff + 12'd1;
                  end
                  if (in_pos_ff >= lag) state_in = S_MUL;
               end else if (req_data.opcode == OP_DRAIN && in_done) begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            prod_in = PROD_W'(row_ff[DIM_W-1:0]) * PROD_W'(cfg.image_width);
            if (elem_ok) begin
               state_in = S_RD;
            end else if (elem_last) begin
               state_in = S_OUT;
            end else if (row_ff == row_last_ff) begin
               row_in = row_first_ff;
               col_in = col_ff + 14'd1;
            end else begin
               row_in = row_ff + 14'd1;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (rd_data > best_ff) best_in = rd_data;
            if (elem_last) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
               if (row_ff == row_last_ff) begin
                  row_in = row_first_ff;
                  col_in = col_ff + 14'd1;
               end else begin
                  row_in = row_ff + 14'd1;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in                 = S_IDLE;
               rsp_valid_in             = 1'b1;
               rsp_data_in.bright_value = best_ff;
               rsp_data_in.row_end      = last_col;
               rsp_data_in.frame_end    = last_col && last_row;
               if (last_col) begin
                  out_col_in = '0;
                  if (last_row) begin
                     out_row_in = '0;
                     in_col_in  = '0;
                     in_row_in  = '0;
                     in_pos_in  = '0;
                  end else begin
                     out_row_in = out_row_ff + 12'd1;
                  end
               end else begin
                  out_col_in = out_col_ff + 12'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // register write restarts the frame
      if (cfg.restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_pos_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_pos_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_pos_ff    <= in_pos_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      col_last_ff  <= col_last_in;
      row_first_ff <= row_first_in;
      row_last_ff  <= row_last_in;
      prod_ff      <= prod_in;
      best_ff      <= best_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a scan that reaches the output step with room always delivers
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> rsp_valid_ff)
      else $error("result not loaded");

   // the store is read only at rows inside the image
   a_rd_in_image: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD) |-> (!row_ff[IDX_W-1] && row_ff < IDX_W'(cfg.image_height)))
      else $error("store read outside image");

   // frame end only on the last pixel of a row
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.frame_end || rsp_data_ff.row_end))
      else $error("frame end without row end");

endmodule
